// ===== rtl/core/tlvp_pkg.sv =====
// Shared types, codes and helpers for the TLV stream parser.
// No dependencies; imported by every module of the parser.
`default_nettype none

package tlvp_pkg;

    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_TRUNC_HEADER = 3'd1,
        ERR_BAD_LENGTH   = 3'd2,
        ERR_ZERO_LENGTH  = 3'd3,
        ERR_TRUNC_VALUE  = 3'd4
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tag;
        logic [15:0] value_length;
        logic        constructed;
        logic [7:0]  value_byte;
        logic        value_last;
        logic [2:0]  error_code;
        logic        run_end;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    function automatic result_t make_result(
        input kind_t       kind,
        input logic [15:0] tag,
        input logic [15:0] len,
        input logic        cons,
        input logic [7:0]  vb,
        input logic        vl,
        input err_t        err
    );
        result_t r;
        r.kind         = kind;
        r.tag          = tag;
        r.value_length = len;
        r.constructed  = cons;
        r.value_byte   = vb;
        r.value_last   = vl;
        r.error_code   = err;
        r.run_end      = 1'b0;
        return r;
    endfunction

    function automatic result_t make_status(input kind_t kind, input err_t err);
        return make_result(kind, 16'h0, 16'h0, 1'b0, 8'h0, 1'b0, err);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tlvp_parse.sv =====
// Parser state registers and the per-byte decode step.
// Depends on tlvp_pkg; yields up to two results per accepted byte.
`default_nettype none

module tlvp_parse (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire tlvp_pkg::item_t       item,
    output tlvp_pkg::result_pair_t     pair
);
    import tlvp_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG1  = 3'd0,
        PH_TAG2  = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LENX  = 3'd3,
        PH_VALUE = 3'd4,
        PH_DRAIN = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] tag_reg, tag_next;
    logic [15:0] len_reg, len_next;
    logic [1:0]  lbl_reg, lbl_next;
    logic [15:0] vbl_reg, vbl_next;
    logic        cons_reg, cons_next;

    always_comb begin
        logic [7:0]  b;
        logic        eod;
        logic        finish;
        logic        last;
        logic [15:0] len_v;
        logic [1:0]  n;
        result_t     r0;
        result_t     r1;

        b      = item.data_byte;
        eod    = item.end_of_data;
        finish = 1'b0;
        last   = 1'b0;
        len_v  = len_reg;
        n      = 2'd0;
        r0     = make_status(KIND_HEADER, ERR_NONE);
        r1     = make_status(KIND_HEADER, ERR_NONE);

        phase_next = phase_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        lbl_next   = lbl_reg;
        vbl_next   = vbl_reg;
        cons_next  = cons_reg;

        case (phase_reg)
            PH_TAG1:
            begin
                tag_next   = {8'h00, b};
                cons_next  = b[5];
                phase_next = (b[4:0] == 5'h1F) ? PH_TAG2 : PH_LEN1;
                if (eod)
                begin
                    r0 = make_status(KIND_ERROR, ERR_TRUNC_HEADER);
                    n  = 2'd1;
                end
            end
            PH_TAG2:
            begin
                tag_next   = {tag_reg[7:0], b};
                phase_next = PH_LEN1;
                if (eod)
                begin
                    r0 = make_status(KIND_ERROR, ERR_TRUNC_HEADER);
                    n  = 2'd1;
                end
            end
            PH_LEN1:
            begin
                if (b[7])
                begin
                    if (b[6:0] inside {7'h01, 7'h02})
                    begin
                        lbl_next   = b[1:0];
                        len_next   = 16'h0;
                        phase_next = PH_LENX;
                        if (eod)
                        begin
                            r0 = make_status(KIND_ERROR, ERR_TRUNC_HEADER);
                            n  = 2'd1;
                        end
                    end
                    else
                    begin
                        r0         = make_status(KIND_ERROR, ERR_BAD_LENGTH);
                        n          = 2'd1;
                        phase_next = PH_DRAIN;
                    end
                end
                else
                begin
                    len_v    = {9'h000, b[6:0]};
                    len_next = len_v;
                    finish   = 1'b1;
                end
            end
            PH_LENX:
            begin
                len_v    = {len_reg[7:0], b};
                len_next = len_v;
                lbl_next = lbl_reg - 2'd1;
                if (lbl_next == 2'd0)
                begin
                    finish = 1'b1;
                end
                else if (eod)
                begin
                    r0 = make_status(KIND_ERROR, ERR_TRUNC_HEADER);
                    n  = 2'd1;
                end
            end
            PH_VALUE:
            begin
                last     = (vbl_reg <= 16'd1);
                r0       = make_result(KIND_VALUE, tag_reg, len_reg, cons_reg, b, last,
                                       ERR_NONE);
                n        = 2'd1;
                vbl_next = last ? 16'h0 : vbl_reg - 16'd1;
                if (last)
                begin
                    phase_next = PH_TAG1;
                    if (eod)
                    begin
                        r1 = make_status(KIND_DONE, ERR_NONE);
                        n  = 2'd2;
                    end
                end
                else if (eod)
                begin
                    r1 = make_status(KIND_ERROR, ERR_TRUNC_VALUE);
                    n  = 2'd2;
                end
            end
            default:
            begin
                phase_next = PH_DRAIN;
            end
        endcase

        if (finish)
        begin
            if (len_v == 16'h0)
            begin
                r0         = make_status(KIND_ERROR, ERR_ZERO_LENGTH);
                n          = 2'd1;
                phase_next = PH_DRAIN;
            end
            else
            begin
                r0 = make_result(KIND_HEADER, tag_reg, len_v, cons_reg, 8'h00, 1'b0,
                                 ERR_NONE);
                n  = 2'd1;
                if (cons_reg)
                begin
                    phase_next = PH_TAG1;
                    if (eod)
                    begin
                        r1 = make_status(KIND_DONE, ERR_NONE);
                        n  = 2'd2;
                    end
                end
                else
                begin
                    vbl_next   = len_v;
                    phase_next = PH_VALUE;
                    if (eod)
                    begin
                        r1 = make_status(KIND_ERROR, ERR_TRUNC_VALUE);
                        n  = 2'd2;
                    end
                end
            end
        end

        if (eod)
        begin
            phase_next = PH_TAG1;
            tag_next   = 16'h0;
            len_next   = 16'h0;
            lbl_next   = 2'd0;
            vbl_next   = 16'h0;
            cons_next  = 1'b0;
        end

        r0.run_end = (n == 2'd1);
        r1.run_end = (n == 2'd2);

        pair.count  = accept ? n : 2'd0;
        pair.first  = r0;
        pair.second = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG1;
            tag_reg   <= 16'h0;
            len_reg   <= 16'h0;
            lbl_reg   <= 2'd0;
            vbl_reg   <= 16'h0;
            cons_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            lbl_reg   <= lbl_next;
            vbl_reg   <= vbl_next;
            cons_reg  <= cons_next;
        end
    end

`ifndef SYNTHESIS
    a_two_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        pair.count == 2'd2 |-> item.end_of_data)
        else $error("two results without end of stream");

    a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.end_of_data |=> phase_reg == PH_TAG1 && vbl_reg == 16'h0)
        else $error("state not cleared after end of stream");

    a_run_end_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pair.count == 2'd2 |-> pair.second.run_end && !pair.first.run_end)
        else $error("run_end not on last result");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tlvp_result_fifo.sv =====
// Four-entry result queue: takes up to two results a cycle, gives one
// unless stalled. Depends on tlvp_pkg for result types and queue sizing.
`default_nettype none

module tlvp_result_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tlvp_pkg::result_pair_t pair,
    output logic                        room,
    output logic                        res_valid,
    input  wire logic                   res_stall,
    output tlvp_pkg::result_t           res_data
);
    import tlvp_pkg::*;

    result_t             mem_reg [FifoDepth];
    logic [FifoPtrW-1:0] head_reg, head_next;
    logic [FifoPtrW-1:0] tail_reg, tail_next;
    logic [FifoCntW-1:0] count_reg, count_next;
    logic                pop;
    logic [FifoPtrW-1:0] tail_plus1;

    assign res_valid  = (count_reg != '0);
    assign res_data   = mem_reg[head_reg];
    assign room       = (count_reg <= FifoCntW'(FifoDepth - 2));
    assign pop        = res_valid && !res_stall;
    assign tail_plus1 = tail_reg + FifoPtrW'(1);
    assign head_next  = head_reg + FifoPtrW'(pop);
    assign tail_next  = tail_reg + FifoPtrW'(pair.count);
    assign count_next = count_reg + FifoCntW'(pair.count) - FifoCntW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair.count != 2'd0)
        begin
            mem_reg[tail_reg] <= pair.first;
        end
        if (pair.count == 2'd2)
        begin
            mem_reg[tail_plus1] <= pair.second;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        pair.count != 2'd0 |-> count_reg <= FifoCntW'(FifoDepth - 2))
        else $error("push into full result queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FifoCntW'(FifoDepth))
        else $error("result queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tlv_stream_parser_unit.sv =====
// Results are registered in a four-entry result queue and leave it in order.
// Throughput: one byte per cycle while req_stall is low; the final byte of a
// stream may give two results; the queue drains one per cycle unless stalled.
// req_stall rises while fewer than two queue entries are free.
// Reset (async, active low) returns the parser to the first tag byte and
// empties the result queue. Depends on tlvp_pkg, tlvp_parse, tlvp_result_fifo.
`default_nettype none

module tlv_stream_parser_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire tlvp_pkg::item_t   req_data,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output tlvp_pkg::result_t      res_data
);
    import tlvp_pkg::*;

    result_pair_t pair;
    logic         room;
    logic         accept;

    assign req_stall = !room;
    assign accept    = req_valid && room;

    tlvp_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (req_data),
        .pair   (pair)
    );

    tlvp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire
